FILE: hw/rtl/arpc_pkg.sv
package arpc_pkg;

  // Table geometry and field widths.
  localparam int ENTRIES  = 16;
  localparam int TAG_BITS = 8;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int STAMP_W  = 32;
  localparam int ST_W     = 2;

  // Depth of the command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // Entry state codes. Code 3 is reserved but is stored as written.
  localparam logic [ST_W-1:0] ENTRY_FREE     = 2'd0;
  localparam logic [ST_W-1:0] ENTRY_PENDING  = 2'd1;
  localparam logic [ST_W-1:0] ENTRY_RESOLVED = 2'd2;

  // Operation codes carried on the func field.
  localparam logic FUNC_SET    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // One classified command as it travels through the queue.
  typedef struct packed {
    logic                lookup;
    logic [IP_W-1:0]     ip;
    logic [MAC_W-1:0]    mac;
    logic [ST_W-1:0]     nst;
    logic                hw;
    logic [TAG_BITS-1:0] tag;
  } cmd_t;

endpackage

FILE: hw/rtl/arp_cache_table_top.sv
// Address resolution cache: sixteen IPv4 to MAC mappings with least recently
// written replacement and waiter wake-up.
//
// The input channel (in_valid, in_ready) carries one command word: func
// selects a set or a lookup. The output channel (out_valid, out_ready)
// returns exactly one result word for every command, in order.
//
// A front end classifies each accepted word and places it in a two-entry
// queue, so the block keeps taking words while the back end is busy or a
// result waits to be taken. The back end walks the table one entry a cycle
// through a single read port. A set stops at the first free or matching
// entry, otherwise it walks all sixteen to find the oldest; a lookup stops
// at the first valid match. The back end takes the next word from the
// queue only after it has finished the scan and committed the result of
// the last one.
//
// Reset marks every entry invalid and clears the use counter and the queue.
// When the receiver stalls, the result holds in the output register, the
// back end waits before committing the next result, and the queue fills and
// then drops in_ready.
module arp_cache_table_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           func,
  input  logic [arpc_pkg::IP_W-1:0]      ip_addr,
  input  logic [arpc_pkg::MAC_W-1:0]     mac_in,
  input  logic [arpc_pkg::ST_W-1:0]      new_state,
  input  logic                           has_waiter,
  input  logic [arpc_pkg::TAG_BITS-1:0]  waiter_tag,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic [arpc_pkg::MAC_W-1:0]     mac_out,
  output logic [arpc_pkg::IDX_W-1:0]     slot,
  output logic                           wake_valid,
  output logic [arpc_pkg::TAG_BITS-1:0]  wake_tag
);

  // Classified command word between the queue and the table engine.
  logic           cmd_valid;
  logic           cmd_ready;
  arpc_pkg::cmd_t cmd;

  arpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .ip_addr    (ip_addr),
    .mac_in     (mac_in),
    .new_state  (new_state),
    .has_waiter (has_waiter),
    .waiter_tag (waiter_tag),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // The table engine owns the entries and the output register.
  arpc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .mac_out    (mac_out),
    .slot       (slot),
    .wake_valid (wake_valid),
    .wake_tag   (wake_tag)
  );

endmodule

FILE: hw/rtl/arpc_front.sv
module arpc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           func,
  input  logic [arpc_pkg::IP_W-1:0]      ip_addr,
  input  logic [arpc_pkg::MAC_W-1:0]     mac_in,
  input  logic [arpc_pkg::ST_W-1:0]      new_state,
  input  logic                           has_waiter,
  input  logic [arpc_pkg::TAG_BITS-1:0]  waiter_tag,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output arpc_pkg::cmd_t                 cmd
);

  arpc_pkg::cmd_t                    q_mem [arpc_pkg::QDEPTH];
  logic [arpc_pkg::QPTR_W-1:0]       wr_ptr;
  logic [arpc_pkg::QPTR_W-1:0]       rd_ptr;
  logic [arpc_pkg::QPTR_W:0]         count;
  arpc_pkg::cmd_t                    new_cmd;
  logic                              push;
  logic                              pop;

  // Classify the incoming word and pack it for the back end.
  always_comb begin
    new_cmd.lookup = (func == arpc_pkg::FUNC_LOOKUP);
    new_cmd.ip     = ip_addr;
    new_cmd.mac    = mac_in;
    new_cmd.nst    = new_state;
    new_cmd.hw     = has_waiter;
    new_cmd.tag    = waiter_tag;
  end

  assign in_ready  = (count != (arpc_pkg::QPTR_W + 1)'(arpc_pkg::QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q_mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == arpc_pkg::QPTR_W'(arpc_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == arpc_pkg::QPTR_W'(arpc_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_cmd;
    end
  end

endmodule

FILE: hw/rtl/arpc_back.sv
module arpc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  arpc_pkg::cmd_t                 cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic [arpc_pkg::MAC_W-1:0]     mac_out,
  output logic [arpc_pkg::IDX_W-1:0]     slot,
  output logic                           wake_valid,
  output logic [arpc_pkg::TAG_BITS-1:0]  wake_tag
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } bstate_t;

  bstate_t                          state;
  arpc_pkg::cmd_t                   cur;
  logic [arpc_pkg::STAMP_W-1:0]     use_counter;
  logic [arpc_pkg::STAMP_W-1:0]     now;
  logic [arpc_pkg::IDX_W-1:0]       idx;

  // Candidate entry gathered during the scan.
  logic [arpc_pkg::IDX_W-1:0]       pick_idx;
  logic                             pick_found;
  logic [arpc_pkg::MAC_W-1:0]       pick_mac;
  logic [arpc_pkg::ST_W-1:0]        pick_state;
  logic                             pick_hw;
  logic [arpc_pkg::TAG_BITS-1:0]    pick_tag;
  logic [arpc_pkg::STAMP_W-1:0]     oldest;

  // The table itself. Only the state array is cleared by reset.
  logic [arpc_pkg::ST_W-1:0]        ent_state [arpc_pkg::ENTRIES];
  logic [arpc_pkg::IP_W-1:0]        ent_ip    [arpc_pkg::ENTRIES];
  logic [arpc_pkg::MAC_W-1:0]       ent_mac   [arpc_pkg::ENTRIES];
  logic [arpc_pkg::STAMP_W-1:0]     ent_stamp [arpc_pkg::ENTRIES];
  logic                             ent_hw    [arpc_pkg::ENTRIES];
  logic [arpc_pkg::TAG_BITS-1:0]    ent_tag   [arpc_pkg::ENTRIES];

  logic [arpc_pkg::ST_W-1:0]        rd_state;
  logic [arpc_pkg::STAMP_W-1:0]     age;
  logic                             ip_eq;
  logic                             lk_match;
  logic                             set_free;
  logic                             last;
  logic                             scan_done;
  logic                             out_free;
  logic                             wake;

  assign rd_state  = ent_state[idx];
  assign ip_eq     = (ent_ip[idx] == cur.ip);
  assign age       = now - ent_stamp[idx];
  assign lk_match  = (rd_state == arpc_pkg::ENTRY_RESOLVED) && ip_eq;
  assign set_free  = (rd_state == arpc_pkg::ENTRY_FREE) || ip_eq;
  assign last      = (idx == arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1));
  assign scan_done = cur.lookup ? (lk_match || last) : (set_free || last);
  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == S_IDLE);
  assign wake      = (pick_state == arpc_pkg::ENTRY_PENDING) && pick_hw &&
                     (cur.nst == arpc_pkg::ENTRY_RESOLVED);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      use_counter <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
        ent_state[i] <= arpc_pkg::ENTRY_FREE;
      end
    end else begin
      // In the finishing state a taken result is replaced by the next one.
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_SCAN;
            if (!cmd.lookup) begin
              use_counter <= use_counter + 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            if (!cur.lookup) begin
              ent_state[pick_idx] <= cur.nst;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cur        <= cmd;
          now        <= use_counter + 1'b1;
          idx        <= '0;
          pick_idx   <= '0;
          pick_found <= 1'b0;
        end
      end
      S_SCAN: begin
        idx <= idx + 1'b1;
        if (cur.lookup) begin
          if (lk_match) begin
            pick_found <= 1'b1;
            pick_idx   <= idx;
            pick_mac   <= ent_mac[idx];
          end
        end else if (set_free || (idx == '0) || (age > oldest)) begin
          // The first free or matching entry wins outright; otherwise the
          // strictly oldest entry so far, which keeps the lowest on a tie.
          pick_idx   <= idx;
          pick_state <= rd_state;
          pick_hw    <= ent_hw[idx];
          pick_tag   <= ent_tag[idx];
          oldest     <= age;
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (cur.lookup) begin
            hit        <= pick_found;
            mac_out    <= pick_found ? pick_mac : '0;
            slot       <= pick_found ? pick_idx : '0;
            wake_valid <= 1'b0;
            wake_tag   <= '0;
          end else begin
            hit                 <= 1'b1;
            mac_out             <= '0;
            slot                <= pick_idx;
            wake_valid          <= wake;
            wake_tag            <= wake ? pick_tag : '0;
            ent_ip[pick_idx]    <= cur.ip;
            ent_mac[pick_idx]   <= cur.mac;
            ent_stamp[pick_idx] <= now;
            ent_hw[pick_idx]    <= cur.hw;
            ent_tag[pick_idx]   <= cur.tag;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/arpc_checker.sv
module arpc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           hit,
  input logic [arpc_pkg::MAC_W-1:0]     mac_out,
  input logic [arpc_pkg::IDX_W-1:0]     slot,
  input logic                           wake_valid,
  input logic [arpc_pkg::TAG_BITS-1:0]  wake_tag
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(mac_out) &&
      $stable(slot) && $stable(wake_valid) && $stable(wake_tag))
    else $error("result word changed while stalled");

  // A miss can only come from a lookup, which reports nothing else.
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> !wake_valid && (mac_out == '0) && (slot == '0))
    else $error("miss carries stray fields");

  // A wake-up is reported only by a set, which always hits and has no MAC.
  a_wake_on_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && wake_valid |-> hit && (mac_out == '0))
    else $error("wake-up outside a set result");

  // The waiter tag reads zero unless a wake-up is reported.
  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !wake_valid |-> (wake_tag == '0))
    else $error("waiter tag without wake-up");

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind arp_cache_table_top arpc_checker u_arpc_checker (.*);
